@@ rtl/core/dbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Depth bucket sorter package
// Sizes, request and status codes, and the item types shared by the
// front end, the back end and the result queue.
// ----------------------------------------------------------------------------
package dbs_pkg;

    // Pool and table sizes.
    localparam int BUCKET_BITS = 10;
    localparam int NODE_BITS   = 12;
    localparam int VERTEX_BITS = 14;
    localparam int OBJECT_BITS = 8;

    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
    localparam int NUM_NODES   = 1 << NODE_BITS;

    // Fixed field widths of the items.
    localparam int DEPTH_BITS  = 32;
    localparam int COUNT_BITS  = 8;
    localparam int STATUS_BITS = 3;
    localparam int REQ_BITS    = 2;
    localparam int BASE_BITS   = (VERTEX_BITS > OBJECT_BITS) ? VERTEX_BITS : OBJECT_BITS;
    localparam int VSUM_BITS   = ((VERTEX_BITS > COUNT_BITS) ? VERTEX_BITS : COUNT_BITS) + 1;

    // Largest finite or infinite magnitude; anything above is a NaN.
    localparam logic [DEPTH_BITS-2:0] INF_MAG = 31'h7F80_0000;

    // Empty list pointer and finished drain position.
    localparam logic [NODE_BITS:0]   NODE_NIL   = {1'b1, {NODE_BITS{1'b0}}};
    localparam logic [BUCKET_BITS:0] DRAIN_END  = {1'b1, {BUCKET_BITS{1'b0}}};

    // Request codes on the input.
    localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd2;

    // Status codes on the output.
    localparam logic [STATUS_BITS-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_BITS-1:0] STAT_REJECTED = 3'd1;
    localparam logic [STATUS_BITS-1:0] STAT_POPPED   = 3'd2;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STATUS_BITS-1:0] STAT_CLEARED  = 3'd4;

    // Command codes between front and back.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_REJECT = 2'd3;

    typedef struct packed {
        logic [REQ_BITS-1:0]   req_type;
        logic [DEPTH_BITS-1:0] depth_bits;
        logic                  kind;
        logic [COUNT_BITS-1:0] vertex_count;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [NODE_BITS-1:0]   node_id;
        logic [BASE_BITS-1:0]   resource_base;
        logic                   is_object;
        logic [BUCKET_BITS-1:0] bucket;
    } t_out_item;

    // Classified request as the back end sees it.
    typedef struct packed {
        logic [1:0]             op;
        logic [BUCKET_BITS-1:0] bucket;
        logic                   is_obj;
        logic [COUNT_BITS-1:0]  count;
    } t_cmd;

    // What a node carries besides its link.
    typedef struct packed {
        logic [BASE_BITS-1:0]   base;
        logic                   is_obj;
        logic [BUCKET_BITS-1:0] bucket;
    } t_node_payload;

endpackage

@@ rtl/core/dbs_front.sv @@
// ----------------------------------------------------------------------------
// Depth bucket sorter front end
// Accepts request items, works out the bucket and the input-only reject
// cases, and holds the resulting commands in a two-entry queue.
// ----------------------------------------------------------------------------
module dbs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    input  dbs_pkg::t_in_item i_item,
    input  logic            i_hold,
    output logic            full,
    output logic            o_cmd_valid,
    output dbs_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_take
);
    import dbs_pkg::*;

    logic [DEPTH_BITS-2:0] mag;
    logic                  neg_real;
    logic                  in_reject;
    t_cmd                  cls;
    logic                  accept;

    t_cmd                  r_q [2];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_count;
    logic                  n_wr_ptr;
    logic                  n_rd_ptr;
    logic [1:0]            n_count;

    // A negative nonzero non-NaN depth counts as depth zero for objects.
    assign mag      = i_item.depth_bits[DEPTH_BITS-2:0];
    assign neg_real = i_item.depth_bits[DEPTH_BITS-1] && (mag != '0) && (mag <= INF_MAG);
    // Vertex groups with a negative depth, and negative zero or a NaN with the sign set, are refused.
    assign in_reject = neg_real ? !i_item.kind : i_item.depth_bits[DEPTH_BITS-1];

    // Classify the request.
    always_comb begin
        cls.bucket = neg_real ? '0
                   : i_item.depth_bits[DEPTH_BITS-2 -: BUCKET_BITS];
        cls.is_obj = i_item.kind;
        cls.count  = i_item.vertex_count;
        unique case (i_item.req_type)
            REQ_INSERT: cls.op = in_reject ? CMD_REJECT : CMD_INSERT;
            REQ_POP:    cls.op = CMD_POP;
            REQ_CLEAR:  cls.op = CMD_CLEAR;
            default:    cls.op = CMD_REJECT;
        endcase
    end

    assign full        = (r_count == 2'd2) || i_hold;
    assign accept      = push && !full;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    // Queue pointers and fill level.
    always_comb begin
        n_wr_ptr = accept ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_cmd_take ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, accept} - {1'b0, i_cmd_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

@@ rtl/core/dbs_back.sv @@
// ----------------------------------------------------------------------------
// Depth bucket sorter back end
// Sequencer over the bucket head memory and the node memories: links
// inserted nodes, walks the buckets for pops, and sweeps the heads on
// reset and on a clear.
// ----------------------------------------------------------------------------
module dbs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_locked,
    input  logic                i_cmd_valid,
    input  dbs_pkg::t_cmd       i_cmd,
    output logic                o_cmd_take,
    input  logic                i_res_space,
    output logic                o_res_valid,
    output dbs_pkg::t_out_item  o_res,
    output logic                o_init
);
    import dbs_pkg::*;

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_INS   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_POP   = 3'd4;

    // Memories.
    logic [NODE_BITS:0] head_mem [NUM_BUCKETS];
    logic [NODE_BITS:0] next_mem [NUM_NODES];
    t_node_payload      pay_mem  [NUM_NODES];

    logic [NODE_BITS:0] r_head_rd;
    logic [NODE_BITS:0] r_next_rd;
    t_node_payload      r_pay_rd;

    logic                   head_we;
    logic [BUCKET_BITS-1:0] head_wr_addr;
    logic [NODE_BITS:0]     head_wr_data;
    logic [BUCKET_BITS-1:0] head_rd_addr;
    logic                   node_we;
    t_node_payload          pay_wr_data;
    logic [NODE_BITS-1:0]   node_rd_addr;

    // Control and pool state.
    logic [2:0]             r_state, n_state;
    logic [BUCKET_BITS-1:0] r_sweep_addr, n_sweep_addr;
    logic                   r_sweep_report, n_sweep_report;
    logic [BUCKET_BITS-1:0] r_max_bucket, n_max_bucket;
    logic [BUCKET_BITS:0]   r_drain_bucket, n_drain_bucket;
    logic [NODE_BITS:0]     r_drain_node, n_drain_node;
    logic [NODE_BITS-1:0]   r_nodes_used, n_nodes_used;
    logic [VERTEX_BITS-1:0] r_vertices_used, n_vertices_used;
    logic [OBJECT_BITS-1:0] r_objects_used, n_objects_used;
    t_cmd                   r_cmd, n_cmd;
    logic [NODE_BITS-1:0]   r_cur_node, n_cur_node;

    logic [VSUM_BITS-1:0]   vert_sum;
    logic                   ins_reject;
    logic                   can_scan;
    logic [BUCKET_BITS:0]   next_bucket;
    logic                   next_scan;
    logic                   start;

    // Pool checks for the insert at the head of the command queue.
    assign vert_sum   = VSUM_BITS'(r_vertices_used) + VSUM_BITS'(i_cmd.count);
    assign ins_reject = i_locked || (&r_nodes_used)
                     || (i_cmd.is_obj ? (&r_objects_used)
                                      : (vert_sum[VSUM_BITS-1:VERTEX_BITS] != '0));

    // Drain position checks.
    assign can_scan    = !r_drain_bucket[BUCKET_BITS]
                      && (r_drain_bucket[BUCKET_BITS-1:0] <= r_max_bucket);
    assign next_bucket = r_drain_bucket + 1'b1;
    assign next_scan   = !next_bucket[BUCKET_BITS]
                      && (next_bucket[BUCKET_BITS-1:0] <= r_max_bucket);

    assign start  = (r_state == ST_IDLE) && i_cmd_valid && i_res_space;
    assign o_init = (r_state == ST_SWEEP) && !r_sweep_report;

    // Sequencer.
    always_comb begin
        n_state         = r_state;
        n_sweep_addr    = r_sweep_addr;
        n_sweep_report  = r_sweep_report;
        n_max_bucket    = r_max_bucket;
        n_drain_bucket  = r_drain_bucket;
        n_drain_node    = r_drain_node;
        n_nodes_used    = r_nodes_used;
        n_vertices_used = r_vertices_used;
        n_objects_used  = r_objects_used;
        n_cmd           = r_cmd;
        n_cur_node      = r_cur_node;
        head_we         = 1'b0;
        head_wr_addr    = r_sweep_addr;
        head_wr_data    = NODE_NIL;
        head_rd_addr    = i_cmd.bucket;
        node_we         = 1'b0;
        node_rd_addr    = r_cur_node;
        pay_wr_data.base   = r_cmd.is_obj ? BASE_BITS'(r_objects_used)
                                          : BASE_BITS'(r_vertices_used);
        pay_wr_data.is_obj = r_cmd.is_obj;
        pay_wr_data.bucket = r_cmd.bucket;
        o_cmd_take      = 1'b0;
        o_res_valid     = 1'b0;
        o_res           = '0;

        unique case (r_state)
            ST_SWEEP: begin
                head_we      = 1'b1;
                n_sweep_addr = r_sweep_addr + 1'b1;
                if (&r_sweep_addr) begin
                    n_state = ST_IDLE;
                    if (r_sweep_report) begin
                        o_res_valid  = 1'b1;
                        o_res.status = STAT_CLEARED;
                    end
                end
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd_take = 1'b1;
                    n_cmd      = i_cmd;
                    unique case (i_cmd.op)
                        CMD_INSERT: begin
                            if (ins_reject) begin
                                o_res_valid  = 1'b1;
                                o_res.status = STAT_REJECTED;
                            end else begin
                                n_state = ST_INS;
                            end
                        end
                        CMD_POP: begin
                            if (!r_drain_node[NODE_BITS]) begin
                                node_rd_addr = r_drain_node[NODE_BITS-1:0];
                                n_cur_node   = r_drain_node[NODE_BITS-1:0];
                                n_state      = ST_POP;
                            end else if (can_scan) begin
                                head_rd_addr = r_drain_bucket[BUCKET_BITS-1:0];
                                n_state      = ST_SCAN;
                            end else begin
                                o_res_valid  = 1'b1;
                                o_res.status = STAT_EMPTY;
                            end
                        end
                        CMD_CLEAR: begin
                            n_max_bucket    = '0;
                            n_drain_bucket  = DRAIN_END;
                            n_drain_node    = NODE_NIL;
                            n_nodes_used    = '0;
                            n_vertices_used = '0;
                            n_objects_used  = '0;
                            n_sweep_addr    = '0;
                            n_sweep_report  = 1'b1;
                            n_state         = ST_SWEEP;
                        end
                        default: begin
                            o_res_valid  = 1'b1;
                            o_res.status = STAT_REJECTED;
                        end
                    endcase
                end
            end
            ST_INS: begin
                // Push the new node on the front of its bucket's list.
                node_we      = 1'b1;
                head_we      = 1'b1;
                head_wr_addr = r_cmd.bucket;
                head_wr_data = {1'b0, r_nodes_used};
                n_nodes_used = r_nodes_used + 1'b1;
                if (r_cmd.is_obj) begin
                    n_objects_used = r_objects_used + 1'b1;
                end else begin
                    n_vertices_used = r_vertices_used + VERTEX_BITS'(r_cmd.count);
                end
                if (r_cmd.bucket > r_max_bucket) begin
                    n_max_bucket = r_cmd.bucket;
                end
                if ({1'b0, r_cmd.bucket} < r_drain_bucket) begin
                    n_drain_bucket = {1'b0, r_cmd.bucket};
                end
                o_res_valid         = 1'b1;
                o_res.status        = STAT_INSERTED;
                o_res.node_id       = r_nodes_used;
                o_res.resource_base = pay_wr_data.base;
                o_res.is_object     = r_cmd.is_obj;
                o_res.bucket        = r_cmd.bucket;
                n_state             = ST_IDLE;
            end
            ST_SCAN: begin
                // Take the bucket's list and empty the bucket; one bucket a cycle.
                head_we        = 1'b1;
                head_wr_addr   = r_drain_bucket[BUCKET_BITS-1:0];
                n_drain_bucket = next_bucket;
                if (!r_head_rd[NODE_BITS]) begin
                    node_rd_addr = r_head_rd[NODE_BITS-1:0];
                    n_cur_node   = r_head_rd[NODE_BITS-1:0];
                    n_state      = ST_POP;
                end else if (next_scan) begin
                    head_rd_addr = next_bucket[BUCKET_BITS-1:0];
                end else begin
                    o_res_valid  = 1'b1;
                    o_res.status = STAT_EMPTY;
                    n_state      = ST_IDLE;
                end
            end
            ST_POP: begin
                n_drain_node = (r_next_rd == {1'b0, r_cur_node}) ? NODE_NIL : r_next_rd;
                o_res_valid         = 1'b1;
                o_res.status        = STAT_POPPED;
                o_res.node_id       = r_cur_node;
                o_res.resource_base = r_pay_rd.base;
                o_res.is_object     = r_pay_rd.is_obj;
                o_res.bucket        = r_pay_rd.bucket;
                n_state             = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_SWEEP;
            r_sweep_addr    <= '0;
            r_sweep_report  <= 1'b0;
            r_max_bucket    <= '0;
            r_drain_bucket  <= DRAIN_END;
            r_drain_node    <= NODE_NIL;
            r_nodes_used    <= '0;
            r_vertices_used <= '0;
            r_objects_used  <= '0;
        end else begin
            r_state         <= n_state;
            r_sweep_addr    <= n_sweep_addr;
            r_sweep_report  <= n_sweep_report;
            r_max_bucket    <= n_max_bucket;
            r_drain_bucket  <= n_drain_bucket;
            r_drain_node    <= n_drain_node;
            r_nodes_used    <= n_nodes_used;
            r_vertices_used <= n_vertices_used;
            r_objects_used  <= n_objects_used;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_cur_node <= n_cur_node;
    end

    // Bucket head memory, one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_wr_addr] <= head_wr_data;
        end
        r_head_rd <= head_mem[head_rd_addr];
    end

    // Node link and payload memories, written at the allocated node.
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            next_mem[r_nodes_used] <= r_head_rd;
            pay_mem[r_nodes_used]  <= pay_wr_data;
        end
        r_next_rd <= next_mem[node_rd_addr];
        r_pay_rd  <= pay_mem[node_rd_addr];
    end

endmodule

@@ rtl/core/dbs_result_q.sv @@
// ----------------------------------------------------------------------------
// Depth bucket sorter result queue
// Two-entry queue that holds finished result items until they are popped.
// ----------------------------------------------------------------------------
module dbs_result_q (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dbs_pkg::t_out_item i_item,
    output logic               o_space,
    input  logic               pop,
    output logic               empty,
    output dbs_pkg::t_out_item o_item
);
    import dbs_pkg::*;

    t_out_item  r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       take;

    assign empty   = (r_count == 2'd0);
    assign o_space = (r_count != 2'd2);
    assign take    = pop && !empty;
    assign o_item  = r_q[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_valid) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (take) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_valid} - {1'b0, take};
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_q[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ rtl/core/depth_bucket_sorter.sv @@
// ----------------------------------------------------------------------------
// Depth bucket sorter
// Sorts inserted nodes into depth buckets and returns them lowest bucket
// first, each bucket last in, first out.
// ----------------------------------------------------------------------------
// Order: a reject or a drained-out pop is answered from the idle state; an insert
// passes the insert state, a pop of a held node the pop state, a pop that walks
// the buckets the scan state per bucket it reaches, then the pop state.
// Throughput: one reject per cycle while the result queue has space; after an insert
// or a pop the back-end sequencer takes no new command until it is back in idle.
// Reset: synchronous, active low; afterwards a sweep empties all 1024 bucket heads
// while full stays high. The locked register resets to 0.
module depth_bucket_sorter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  dbs_pkg::t_in_item  i_req,
    output logic               empty,
    input  logic               pop,
    output dbs_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import dbs_pkg::*;

    logic      r_locked;
    logic      cmd_valid;
    t_cmd      cmd;
    logic      cmd_take;
    logic      res_space;
    logic      res_valid;
    t_out_item res;
    logic      init;

    // Lock register; always writable.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= 1'b0;
        end else if (i_cfg_valid) begin
            r_locked <= i_cfg_data;
        end
    end

    dbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_req),
        .i_hold      (init),
        .full        (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    dbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_locked    (r_locked),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_res_space (res_space),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_init      (init)
    );

    dbs_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_item  (res),
        .o_space (res_space),
        .pop     (pop),
        .empty   (empty),
        .o_item  (o_result)
    );

endmodule
